[design/tvdr_pkg.sv]
`timescale 1ns / 1ps
// tvdr_pkg: types, register indexes and constants for the triangle vertex depth block.
// No dependencies; imported by every other file in design/.
package tvdr_pkg;

    localparam int TVDR_QUEUE_DEPTH = 2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_DEPTH_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BIAS_ENABLE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH_OFFSET = 2'd2;

    localparam logic [1:0] MODE_Z = 2'd0;
    localparam logic [1:0] MODE_W = 2'd1;

    localparam logic [1:0] VTX_A = 2'd0;
    localparam logic [1:0] VTX_B = 2'd1;
    localparam logic [1:0] VTX_C = 2'd2;

    localparam logic [15:0] DEPTH_MAX     = 16'hffff;
    localparam logic [15:0] W_EMPTY_DEPTH = 16'hf001;
    localparam logic [4:0]  W_SHIFT_BASE  = 5'd19;

    typedef struct packed {
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] bx;
        logic signed [15:0] by;
        logic signed [15:0] cx;
        logic signed [15:0] cy;
        logic signed [63:0] depth_start;
        logic signed [63:0] depth_grad_x;
        logic signed [63:0] depth_grad_y;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  vertex_index;
        logic [15:0] depth_value;
        logic        last_vertex;
    } out_item_t;

    // triangle after the front end: offsets of B and C from A
    typedef struct packed {
        logic signed [16:0] dx_b;
        logic signed [16:0] dy_b;
        logic signed [16:0] dx_c;
        logic signed [16:0] dy_c;
        logic        [63:0] start;
        logic        [63:0] grad_x;
        logic        [63:0] grad_y;
    } tri_t;

    typedef struct packed {
        logic [1:0]  depth_mode;
        logic        bias_enable;
        logic [15:0] depth_offset;
    } cfg_t;

endpackage

[design/tvdr_front.sv]
`timescale 1ns / 1ps
// tvdr_front: accepts triangle items and forms vertex offsets relative to vertex A.
// Depends on tvdr_pkg; feeds tvdr_queue.
module tvdr_front import tvdr_pkg::*; (
    input  logic     s_valid,
    output logic     s_ready,
    input  in_item_t s_item,
    input  logic     q_full,
    output logic     q_push,
    output tri_t     q_data
);

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    always_comb begin
        q_data.dx_b   = {s_item.bx[15], s_item.bx} - {s_item.ax[15], s_item.ax};
        q_data.dy_b   = {s_item.by[15], s_item.by} - {s_item.ay[15], s_item.ay};
        q_data.dx_c   = {s_item.cx[15], s_item.cx} - {s_item.ax[15], s_item.ax};
        q_data.dy_c   = {s_item.cy[15], s_item.cy} - {s_item.ay[15], s_item.ay};
        q_data.start  = s_item.depth_start;
        q_data.grad_x = s_item.depth_grad_x;
        q_data.grad_y = s_item.depth_grad_y;
    end

endmodule

[design/tvdr_queue.sv]
`timescale 1ns / 1ps
// tvdr_queue: short register FIFO of triangles between front and back ends.
// Depends on tvdr_pkg.
module tvdr_queue import tvdr_pkg::*; #(
    parameter int DEPTH = TVDR_QUEUE_DEPTH
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  tri_t push_data,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output tri_t head_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    tri_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[design/tvdr_back.sv]
`timescale 1ns / 1ps
// tvdr_back: walks vertices A, B, C of the queued triangle through the depth pipeline
// (split multiply, sum, divide by 16, start add, mode conversion, bias). Depends on tvdr_pkg.
module tvdr_back import tvdr_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  cfg_t      cfg,
    input  logic      q_valid,
    input  tri_t      q_data,
    output logic      q_pop,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    function automatic logic [3:0] lzc16(input logic [15:0] v);
        logic [3:0] n;
        n = '0;
        for (int i = 0; i < 16; i++) begin
            if (v[i]) begin
                n = 4'(15 - i);
            end
        end
        return n;
    endfunction

    logic       advance;
    logic [1:0] cnt_reg, cnt_next;

    // stage valid and vertex index
    logic       v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic [1:0] i1_reg, i2_reg, i3_reg, i4_reg, i5_reg;

    // payload
    logic [63:0]        st1_reg, st2_reg, st3_reg;
    logic signed [49:0] mxl_reg, myl_reg;
    logic signed [48:0] mxh_reg, myh_reg;
    logic [80:0]        px_reg, py_reg;
    logic [81:0]        s_reg;
    logic [63:0]        d_reg;
    logic [15:0]        base_reg;

    logic               m_valid_reg;
    out_item_t          m_item_reg;

    // issue
    logic signed [16:0] dx, dy;
    logic signed [32:0] gxl, gyl;
    logic signed [31:0] gxh, gyh;
    logic signed [49:0] mxl_next, myl_next;
    logic signed [48:0] mxh_next, myh_next;
    logic [80:0]        px_next, py_next;
    logic [81:0]        s_next;
    logic [63:0]        d_next;
    logic               rnd;

    // mode conversion
    logic [31:0] zu;
    logic [15:0] z_depth;
    logic [3:0]  e;
    logic [4:0]  sh;
    logic [31:0] winv;
    logic [11:0] m;
    logic [16:0] wd;
    logic [15:0] w_depth;
    logic [15:0] base_next;
    logic [17:0] bsum;
    logic [15:0] depth_next;

    assign advance = !m_valid_reg || m_ready;
    assign q_pop   = advance && q_valid && (cnt_reg == VTX_C);
    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    always_comb begin
        cnt_next = cnt_reg;
        if (advance && q_valid) begin
            cnt_next = (cnt_reg == VTX_C) ? VTX_A : cnt_reg + 1'b1;
        end
    end

    always_comb begin
        case (cnt_reg)
            VTX_B: begin
                dx = q_data.dx_b;
                dy = q_data.dy_b;
            end
            VTX_C: begin
                dx = q_data.dx_c;
                dy = q_data.dy_c;
            end
            default: begin
                dx = '0;
                dy = '0;
            end
        endcase
    end

    assign gxl      = $signed({1'b0, q_data.grad_x[31:0]});
    assign gyl      = $signed({1'b0, q_data.grad_y[31:0]});
    assign gxh      = $signed(q_data.grad_x[63:32]);
    assign gyh      = $signed(q_data.grad_y[63:32]);
    assign mxl_next = gxl * dx;
    assign myl_next = gyl * dy;
    assign mxh_next = gxh * dx;
    assign myh_next = gyh * dy;

    assign px_next = {mxh_reg, 32'd0} + {{31{mxl_reg[49]}}, mxl_reg};
    assign py_next = {myh_reg, 32'd0} + {{31{myl_reg[49]}}, myl_reg};
    assign s_next  = {px_reg[80], px_reg} + {py_reg[80], py_reg};

    // truncation toward zero: round up negative sums with a remainder
    assign rnd    = s_reg[81] && (s_reg[3:0] != 4'd0);
    assign d_next = st3_reg + s_reg[67:4] + {63'd0, rnd};

    // linear Z
    assign zu = d_reg[43:12];
    always_comb begin
        if (zu[31]) begin
            z_depth = '0;
        end else if (zu[30:16] != '0) begin
            z_depth = DEPTH_MAX;
        end else begin
            z_depth = zu[15:0];
        end
    end

    // logarithmic W
    assign e    = lzc16(d_reg[31:16]);
    assign sh   = W_SHIFT_BASE - {1'b0, e};
    assign winv = ~d_reg[31:0];
    assign m    = 12'(winv >> sh);
    assign wd   = {1'b0, e, 12'd0} + {5'd0, m} + 17'd1;
    always_comb begin
        if (d_reg[47:32] != '0) begin
            w_depth = '0;
        end else if (d_reg[31:16] == '0) begin
            w_depth = W_EMPTY_DEPTH;
        end else if (wd[16]) begin
            w_depth = DEPTH_MAX;
        end else begin
            w_depth = wd[15:0];
        end
    end

    always_comb begin
        case (cfg.depth_mode)
            MODE_Z:  base_next = z_depth;
            MODE_W:  base_next = w_depth;
            default: base_next = cfg.depth_offset;
        endcase
    end

    assign bsum = {2'b00, base_reg} + {{2{cfg.depth_offset[15]}}, cfg.depth_offset};
    always_comb begin
        if (cfg.depth_mode != MODE_Z && cfg.depth_mode != MODE_W) begin
            depth_next = cfg.depth_offset;
        end else if (!cfg.bias_enable) begin
            depth_next = base_reg;
        end else if (bsum[17]) begin
            depth_next = '0;
        end else if (bsum[16]) begin
            depth_next = DEPTH_MAX;
        end else begin
            depth_next = bsum[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= VTX_A;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            v5_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            if (advance) begin
                v1_reg      <= q_valid;
                v2_reg      <= v1_reg;
                v3_reg      <= v2_reg;
                v4_reg      <= v3_reg;
                v5_reg      <= v4_reg;
                m_valid_reg <= v5_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            i1_reg   <= cnt_reg;
            st1_reg  <= q_data.start;
            mxl_reg  <= mxl_next;
            myl_reg  <= myl_next;
            mxh_reg  <= mxh_next;
            myh_reg  <= myh_next;
            i2_reg   <= i1_reg;
            st2_reg  <= st1_reg;
            px_reg   <= px_next;
            py_reg   <= py_next;
            i3_reg   <= i2_reg;
            st3_reg  <= st2_reg;
            s_reg    <= s_next;
            i4_reg   <= i3_reg;
            d_reg    <= d_next;
            i5_reg   <= i4_reg;
            base_reg <= base_next;
            m_item_reg.vertex_index <= i5_reg;
            m_item_reg.depth_value  <= depth_next;
            m_item_reg.last_vertex  <= (i5_reg == VTX_C);
        end
    end

endmodule

[design/triangle_vertex_depth_reconstruct.sv]
`timescale 1ns / 1ps
// Triangle vertex depth reconstruction: three 16-bit vertex depths (A, B, C) per triangle.
// Path: vertex A runs through the queue and the stage registers to m_item; B and C follow.
// Throughput: one result per cycle unless m_ready stalls the output, set by the single
// vertex datapath that each triangle visits three times.
// Reset: synchronous active-low aresetn clears the queue, pipeline and config registers.
module triangle_vertex_depth_reconstruct import tvdr_pkg::*; #(
    parameter int QUEUE_DEPTH = TVDR_QUEUE_DEPTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_item,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_item,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_idx,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    cfg_t cfg_reg;
    logic q_push, q_full, q_pop, q_valid;
    tri_t q_in, q_head;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_idx)
                REG_DEPTH_MODE:   cfg_reg.depth_mode   <= cfg_wdata[1:0];
                REG_BIAS_ENABLE:  cfg_reg.bias_enable  <= cfg_wdata[0];
                REG_DEPTH_OFFSET: cfg_reg.depth_offset <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    tvdr_front u_front (
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_data  (q_in)
    );

    tvdr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_data  (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_data  (q_head)
    );

    tvdr_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .q_valid (q_valid),
        .q_data  (q_head),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

endmodule
